[hdl/tsp_pkg.sv]
// Shared types and constants for the two-sum pair finder.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package tsp_pkg;

    localparam int VALUE_W   = 32;
    localparam int OUT_IDX_W = 16;
    localparam int STATUS_W  = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED     = 2'd0,
        ST_MATCH      = 2'd1,
        ST_IGNORED    = 2'd2,
        ST_NOT_STORED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

[hdl/tsp_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tsp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/two_sum_pair_finder.sv]
// Two-sum pair finder: top level with scan sequencer, counters and output register.
// Depends on tsp_pkg and tsp_ram.
`timescale 1ns / 1ps

// Usage
// - Input channel (i_in_valid / o_in_ready) carries one list value per transfer;
//   i_first_of_list marks the first value of a new list and empties the table.
// - Output channel (o_out_valid / i_out_ready) returns one result per input:
//   status, partner index (non-zero only on a match) and the item's own index.
// - target_sum is written through i_cfg_we / i_cfg_wdata while the block is idle.
// - Each looked-up item scans the stored entries through one RAM read port, one
//   entry per cycle, comparing against the complement and the value itself.
//   The result is registered once the scan ends, and the next input is taken
//   only after that result has been loaded into the output register. Items
//   ignored after a match, or past the index limit, skip the scan.
// - The table is tracked by a fill count: entries are taken in order, so no
//   clearing pass is needed, neither at reset nor at the start of a list.
// - Reset empties the table, clears the counter, the match flag and target_sum.
// - A stalled receiver holds the result in the output register; the block takes
//   the next input meanwhile and waits with its following result until the
//   register is free.

module two_sum_pair_finder #(
    parameter int TABLE_ENTRIES = 256,
    parameter int INDEX_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic signed [tsp_pkg::VALUE_W-1:0]  i_cfg_wdata,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [tsp_pkg::VALUE_W-1:0]  i_value,
    input  logic                                i_first_of_list,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tsp_pkg::STATUS_W-1:0]        o_status,
    output logic [tsp_pkg::OUT_IDX_W-1:0]       o_partner_index,
    output logic [tsp_pkg::OUT_IDX_W-1:0]       o_own_index
);

    import tsp_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_ENTRIES);
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
    localparam int RAM_W  = VALUE_W + INDEX_BITS;

    // control state
    t_state                r_state, n_state;
    logic [FILL_W-1:0]     r_fill, n_fill;
    logic [INDEX_BITS:0]   r_count, n_count;
    logic                  r_match, n_match;
    logic [FILL_W-1:0]     r_addr, n_addr;
    logic                  r_pend, n_pend;
    logic                  r_same_vld, n_same_vld;
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_target;

    // item payload
    logic [ADDR_W-1:0]     r_pend_addr, n_pend_addr;
    logic [ADDR_W-1:0]     r_same_slot, n_same_slot;
    logic [VALUE_W-1:0]    r_value, n_value;
    logic [VALUE_W-1:0]    r_comp, n_comp;
    logic                  r_in_range, n_in_range;
    t_status               r_res_status, n_res_status;
    logic [INDEX_BITS-1:0] r_res_partner, n_res_partner;
    logic [INDEX_BITS-1:0] r_own, n_own;
    t_status               r_o_status;
    logic [OUT_IDX_W-1:0]  r_o_partner;
    logic [OUT_IDX_W-1:0]  r_o_own;

    // RAM port
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic                  ram_re;
    logic [RAM_W-1:0]      ram_rdata;
    logic [VALUE_W-1:0]    rd_val;
    logic [INDEX_BITS-1:0] rd_idx;

    // decode
    logic [VALUE_W:0]      comp_wide;
    logic [INDEX_BITS:0]   eff_count;
    logic                  eff_match;
    logic                  acc_scan;
    logic                  in_xfer;
    logic                  scan_hit;
    logic                  scan_same;
    logic                  scan_issue;
    logic                  scan_end;
    logic                  table_full;
    logic                  out_load;

    tsp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_value, r_own}),
        .i_re    (ram_re),
        .i_raddr (r_addr[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_val = ram_rdata[RAM_W-1 -: VALUE_W];
    assign rd_idx = ram_rdata[INDEX_BITS-1:0];

    // Complement at full precision; it fits 32 bits when the top two bits agree.
    assign comp_wide = {r_target[VALUE_W-1], r_target} - {i_value[VALUE_W-1], i_value};

    // A new list restarts the counter and forgets any earlier match.
    assign eff_count = i_first_of_list ? '0 : r_count;
    assign eff_match = i_first_of_list ? 1'b0 : r_match;
    assign acc_scan  = !eff_count[INDEX_BITS] && !eff_match;

    assign in_xfer    = i_in_valid && o_in_ready;
    assign table_full = (r_fill == FILL_W'(TABLE_ENTRIES));

    // Data read in the previous cycle is compared now; a new read goes out
    // while the pointer is still below the fill count.
    assign scan_hit   = (r_state == S_SCAN) && r_pend && r_in_range && (rd_val == r_comp);
    assign scan_same  = (r_state == S_SCAN) && r_pend && (rd_val == r_value);
    assign scan_issue = (r_addr < r_fill);
    assign scan_end   = (r_state == S_SCAN) && !scan_hit && !scan_issue;

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = acc_scan ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (scan_hit || scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and table control
    always_comb begin
        n_fill        = r_fill;
        n_count       = r_count;
        n_match       = r_match;
        n_addr        = r_addr;
        n_pend        = 1'b0;
        n_pend_addr   = r_pend_addr;
        n_same_vld    = r_same_vld;
        n_same_slot   = r_same_slot;
        n_value       = r_value;
        n_comp        = r_comp;
        n_in_range    = r_in_range;
        n_res_status  = r_res_status;
        n_res_partner = r_res_partner;
        n_own         = r_own;
        ram_we        = 1'b0;
        ram_waddr     = r_fill[ADDR_W-1:0];
        ram_re        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_first_of_list) begin
                        n_fill = '0;
                    end
                    n_match       = eff_match;
                    n_value       = i_value;
                    n_comp        = comp_wide[VALUE_W-1:0];
                    n_in_range    = (comp_wide[VALUE_W] == comp_wide[VALUE_W-1]);
                    n_addr        = '0;
                    n_same_vld    = 1'b0;
                    n_res_partner = '0;
                    if (eff_count[INDEX_BITS]) begin
                        // index space used up: saturate and hold the counter
                        n_count      = eff_count;
                        n_own        = '1;
                        n_res_status = eff_match ? ST_IGNORED : ST_NOT_STORED;
                    end else begin
                        n_count      = eff_count + (INDEX_BITS + 1)'(1);
                        n_own        = eff_count[INDEX_BITS-1:0];
                        n_res_status = ST_IGNORED;
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_res_status  = ST_MATCH;
                    n_res_partner = rd_idx;
                    n_match       = 1'b1;
                end else begin
                    if (scan_issue) begin
                        ram_re      = 1'b1;
                        n_addr      = r_addr + FILL_W'(1);
                        n_pend      = 1'b1;
                        n_pend_addr = r_addr[ADDR_W-1:0];
                    end
                    if (scan_same) begin
                        n_same_vld  = 1'b1;
                        n_same_slot = r_pend_addr;
                    end
                    if (scan_end) begin
                        if (r_same_vld || scan_same) begin
                            // overwrite the entry that already holds this value
                            ram_we       = 1'b1;
                            ram_waddr    = r_same_vld ? r_same_slot : r_pend_addr;
                            n_res_status = ST_STORED;
                        end else if (!table_full) begin
                            ram_we       = 1'b1;
                            ram_waddr    = r_fill[ADDR_W-1:0];
                            n_fill       = r_fill + FILL_W'(1);
                            n_res_status = ST_STORED;
                        end else begin
                            n_res_status = ST_NOT_STORED;
                        end
                    end
                end
            end
            S_DONE: begin
                n_pend = 1'b0;
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_count    <= '0;
            r_match    <= 1'b0;
            r_addr     <= '0;
            r_pend     <= 1'b0;
            r_same_vld <= 1'b0;
            r_target   <= '0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_count    <= n_count;
            r_match    <= n_match;
            r_addr     <= n_addr;
            r_pend     <= n_pend;
            r_same_vld <= n_same_vld;
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_addr   <= n_pend_addr;
        r_same_slot   <= n_same_slot;
        r_value       <= n_value;
        r_comp        <= n_comp;
        r_in_range    <= n_in_range;
        r_res_status  <= n_res_status;
        r_res_partner <= n_res_partner;
        r_own         <= n_own;
    end

    // output register: load a finished result once the slot is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status  <= r_res_status;
            r_o_partner <= OUT_IDX_W'(r_res_partner);
            r_o_own     <= OUT_IDX_W'(r_own);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_partner_index = r_o_partner;
    assign o_own_index     = r_o_own;

    // assertions
    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_count_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[INDEX_BITS] |-> (r_count[INDEX_BITS-1:0] == '0))
        else $error("item counter ran past its limit");

    a_partner_earlier : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_status == ST_MATCH) |-> (r_res_partner < r_own))
        else $error("match partner is not an earlier item");

    a_read_in_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_pend) |-> (FILL_W'(r_pend_addr) < r_fill))
        else $error("compared an entry outside the filled part of the table");

    a_write_slot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (FILL_W'(ram_waddr) < r_fill || (FILL_W'(ram_waddr) == r_fill && !table_full)))
        else $error("table write beyond the next free entry");

    a_no_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && acc_scan |=> (r_state == S_SCAN && !r_pend && r_addr == '0))
        else $error("scan did not restart cleanly after an input transfer");

endmodule
